### rtl/scaled_matrix_multiply_accumulate_unit_assert.svh
// Assertion macros shared by the scaled matrix multiply-accumulate RTL.
`ifndef SCALED_MATRIX_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH
`define SCALED_MATRIX_MULTIPLY_ACCUMULATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMMA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/smma_pkg.sv
// Shared types, constants and helper functions of the matrix multiply-accumulate unit.
package smma_pkg;

  localparam int MAX_DIM_DEF   = 64;
  localparam int ELEM_BITS_DEF = 16;

  localparam int DIM_W    = 7;   // size registers and inner tap counter
  localparam int IDX_W    = 6;   // row and column fields
  localparam int VALUE_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int RESULT_W = 32;
  localparam int CHUNK_W  = 16;  // slice of the dot product fed to the alpha multiplier
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ROWS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BETA  = 3'd4;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_LOAD_C  = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_e;

  // Sizes already clamped to the store dimension.
  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  inner;
    logic [DIM_W-1:0]  cols;
    logic [GAIN_W-1:0] alpha;
    logic [GAIN_W-1:0] beta;
  } cfg_t;

  typedef struct packed {
    logic             accept;
    logic             start;
    logic             mac_issue;
    logic [DIM_W-1:0] tap;
    logic             c_read;
    logic             scale_step;
    logic             rsp_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_compute;
    logic in_range;
    logic scale_last;
  } dp_status_t;

  // Accumulator width, wide enough for a dot product over max_dim terms.
  function automatic int acc_width(input int max_dim, input int elem_bits);
    return 2 * elem_bits + $clog2(max_dim) + 1;
  endfunction

  function automatic int chunk_count(input int acc_w);
    return (acc_w + CHUNK_W - 1) / CHUNK_W;
  endfunction

endpackage

### rtl/smma_if.sv
// Request and result channel interfaces of the matrix multiply-accumulate unit.
interface smma_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic [smma_pkg::IDX_W-1:0]          row;
  logic [smma_pkg::IDX_W-1:0]          col;
  logic signed [smma_pkg::VALUE_W-1:0] value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface smma_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [smma_pkg::IDX_W-1:0]           out_row;
  logic [smma_pkg::IDX_W-1:0]           out_col;
  logic signed [smma_pkg::RESULT_W-1:0] result;
  logic                                 range_error;

  modport source (output valid, out_row, out_col, result, range_error, input ready);
  modport sink   (input valid, out_row, out_col, result, range_error, output ready);
endinterface

### rtl/smma_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module smma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/smma_regs.sv
// APB configuration registers with size clamping.
module smma_regs #(
  parameter int MAX_DIM = smma_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smma_pkg::PADDR_W-1:0]  paddr,
  input  logic [smma_pkg::PDATA_W-1:0]  pwdata,
  output logic [smma_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output smma_pkg::cfg_t                cfg_o
);

  localparam int DW = smma_pkg::DIM_W;
  localparam int GW = smma_pkg::GAIN_W;
  localparam int PW = smma_pkg::PDATA_W;

  logic [DW-1:0] rows_q, inner_q, cols_q;
  logic [GW-1:0] alpha_q, beta_q;
  logic          wr_en;
  logic [smma_pkg::REG_IDX_W-1:0] reg_idx;

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] n);
    if (32'(n) > 32'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end
    return n;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[smma_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DW'(64);
      inner_q <= DW'(64);
      cols_q  <= DW'(64);
      alpha_q <= GW'(256);
      beta_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        smma_pkg::REG_ROWS:  rows_q  <= pwdata[DW-1:0];
        smma_pkg::REG_INNER: inner_q <= pwdata[DW-1:0];
        smma_pkg::REG_COLS:  cols_q  <= pwdata[DW-1:0];
        smma_pkg::REG_ALPHA: alpha_q <= pwdata[GW-1:0];
        smma_pkg::REG_BETA:  beta_q  <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      smma_pkg::REG_ROWS:  prdata = PW'(rows_q);
      smma_pkg::REG_INNER: prdata = PW'(inner_q);
      smma_pkg::REG_COLS:  prdata = PW'(cols_q);
      smma_pkg::REG_ALPHA: prdata = PW'(alpha_q);
      smma_pkg::REG_BETA:  prdata = PW'(beta_q);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.rows  = clamp_dim(rows_q);
  assign cfg_o.inner = clamp_dim(inner_q);
  assign cfg_o.cols  = clamp_dim(cols_q);
  assign cfg_o.alpha = alpha_q;
  assign cfg_o.beta  = beta_q;

endmodule

### rtl/smma_ctrl.sv
// Sequencing state machine: load accept, inner-dimension walk, scaling and result hand-off.
`include "scaled_matrix_multiply_accumulate_unit_assert.svh"

module smma_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smma_pkg::cfg_t       cfg_i,
  input  smma_pkg::dp_status_t stat_i,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output smma_pkg::ctrl_cmd_t  cmd_o
);

  localparam int DW = smma_pkg::DIM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_FINAL = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [DW-1:0] tap_q, tap_d;
  logic          drain_q, drain_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic          accept;
  logic          compute_go;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign compute_go  = accept && stat_i.is_compute;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d          = state_q;
    tap_d            = tap_q;
    drain_d          = drain_q;
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.start      = compute_go;
    cmd_o.tap        = tap_q;
    unique case (state_q)
      ST_IDLE: begin
        if (compute_go) begin
          if (!stat_i.in_range) begin
            state_d = ST_FINAL;
          end else if (cfg_i.inner == '0) begin
            state_d = ST_DRAIN;
            drain_d = 1'b0;
          end else begin
            state_d = ST_MAC;
            tap_d   = '0;
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (tap_q == cfg_i.inner - DW'(1)) begin
          state_d = ST_DRAIN;
          drain_d = 1'b0;
        end else begin
          tap_d = tap_q + DW'(1);
        end
      end
      ST_DRAIN: begin
        // The drain state lets the read and product stages empty into the accumulator.
        cmd_o.c_read = !drain_q;
        if (drain_q) begin
          state_d = ST_SCALE;
        end else begin
          drain_d = 1'b1;
        end
      end
      ST_SCALE: begin
        cmd_o.scale_step = 1'b1;
        if (stat_i.scale_last) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_q       <= '0;
      drain_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      drain_q     <= drain_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  `SMMA_ASSERT_NOW(a_tap_in_range, clk_i, rst_ni, cmd_o.mac_issue, tap_q < cfg_i.inner, "inner tap beyond configured size")
  `SMMA_ASSERT_NEXT(a_mac_entry, clk_i, rst_ni, compute_go && stat_i.in_range && (cfg_i.inner != '0), state_q == ST_MAC, "in-range compute did not start the inner walk")
  `SMMA_ASSERT_NEXT(a_scale_hold, clk_i, rst_ni, (state_q == ST_SCALE) && !stat_i.scale_last, state_q == ST_SCALE, "scaling left before the last slice")
  `SMMA_ASSERT_NOW(a_rsp_from_final, clk_i, rst_ni, $rose(rsp_valid_q), $past(state_q) == ST_FINAL, "result raised outside the final step")

endmodule

### rtl/smma_dp.sv
// Datapath: element stores, multiply-accumulate, alpha/beta scaling and result register.
module smma_dp #(
  parameter int MAX_DIM   = smma_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = smma_pkg::ELEM_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  smma_pkg::cfg_t                       cfg_i,
  input  smma_pkg::ctrl_cmd_t                  cmd_i,
  output smma_pkg::dp_status_t                 stat_o,
  input  logic [1:0]                           req_kind_i,
  input  logic [smma_pkg::IDX_W-1:0]           req_row_i,
  input  logic [smma_pkg::IDX_W-1:0]           req_col_i,
  input  logic signed [smma_pkg::VALUE_W-1:0]  req_value_i,
  output logic [smma_pkg::IDX_W-1:0]           rsp_row_o,
  output logic [smma_pkg::IDX_W-1:0]           rsp_col_o,
  output logic signed [smma_pkg::RESULT_W-1:0] rsp_result_o,
  output logic                                 rsp_error_o
);

  localparam int DW     = smma_pkg::DIM_W;
  localparam int CW     = smma_pkg::CHUNK_W;
  localparam int GW     = smma_pkg::GAIN_W;
  localparam int RW_OUT = smma_pkg::RESULT_W;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int P_W    = 2 * ELEM_BITS;
  localparam int ACC_W  = smma_pkg::acc_width(MAX_DIM, ELEM_BITS);
  localparam int NCH    = smma_pkg::chunk_count(ACC_W);
  localparam int CHK_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PAD_W  = NCH * CW;
  localparam int R_W    = PAD_W + GW;
  localparam int BC_W   = GW + ELEM_BITS;
  localparam int S_W    = R_W - 7;
  localparam logic signed [S_W-1:0] SAT_HI = S_W'(2147483647);
  localparam logic signed [S_W-1:0] SAT_LO = -SAT_HI - S_W'(1);
  localparam logic [CHK_W-1:0] TOP_CHUNK = CHK_W'(NCH - 1);

  function automatic logic [ADDR_W-1:0] flat_addr(input logic [DW-1:0] r,
                                                  input logic [DW-1:0] c);
    flat_addr = ADDR_W'(32'(r) * 32'(MAX_DIM) + 32'(c));
  endfunction

  logic [DW-1:0] row_ext, col_ext, row_q, col_q;
  logic          in_range, err_q;
  logic          we_a, we_b, we_c;
  logic [ADDR_W-1:0] load_addr;
  logic signed [ELEM_BITS-1:0] load_elem;
  logic [ELEM_BITS-1:0] a_rdata, b_rdata, c_rdata;

  logic                     rd_vld_q, prod_vld_q;
  logic signed [P_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic [CHK_W-1:0]         chunk_q;
  logic signed [PAD_W-1:0]  dot_pad;
  logic [CW-1:0]            chunk;
  logic signed [CW:0]       chunk_op;
  logic signed [GW+CW:0]    part;
  logic signed [R_W-1:0]    r_q;
  logic signed [BC_W-1:0]   bc_q;

  logic signed [R_W-9:0]    scaled;
  logic signed [S_W-1:0]    sum;
  logic signed [RW_OUT-1:0] sat;

  // Index checks against the clamped sizes.
  assign row_ext = {1'b0, req_row_i};
  assign col_ext = {1'b0, req_col_i};

  always_comb begin
    unique case (req_kind_i)
      smma_pkg::KIND_LOAD_A: in_range = (row_ext < cfg_i.rows)  && (col_ext < cfg_i.inner);
      smma_pkg::KIND_LOAD_B: in_range = (row_ext < cfg_i.inner) && (col_ext < cfg_i.cols);
      default:               in_range = (row_ext < cfg_i.rows)  && (col_ext < cfg_i.cols);
    endcase
  end

  assign stat_o.is_compute = (req_kind_i == smma_pkg::KIND_COMPUTE);
  assign stat_o.in_range   = in_range;
  assign stat_o.scale_last = (chunk_q == '0);

  // Loads write straight from the accepted request.
  assign load_addr = flat_addr(row_ext, col_ext);
  assign load_elem = ELEM_BITS'(req_value_i);
  assign we_a = cmd_i.accept && in_range && (req_kind_i == smma_pkg::KIND_LOAD_A);
  assign we_b = cmd_i.accept && in_range && (req_kind_i == smma_pkg::KIND_LOAD_B);
  assign we_c = cmd_i.accept && in_range && (req_kind_i == smma_pkg::KIND_LOAD_C);

  smma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (load_addr),
    .wdata_i (load_elem),
    .re_i    (cmd_i.mac_issue),
    .raddr_i (flat_addr(row_q, cmd_i.tap)),
    .rdata_o (a_rdata)
  );

  smma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (load_addr),
    .wdata_i (load_elem),
    .re_i    (cmd_i.mac_issue),
    .raddr_i (flat_addr(cmd_i.tap, col_q)),
    .rdata_o (b_rdata)
  );

  smma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (load_addr),
    .wdata_i (load_elem),
    .re_i    (cmd_i.c_read),
    .raddr_i (flat_addr(row_q, col_q)),
    .rdata_o (c_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      chunk_q    <= '0;
    end else begin
      rd_vld_q   <= cmd_i.mac_issue;
      prod_vld_q <= rd_vld_q;
      if (cmd_i.start) begin
        chunk_q <= TOP_CHUNK;
      end else if (cmd_i.scale_step) begin
        chunk_q <= chunk_q - CHK_W'(1);
      end
    end
  end

  // Latch the compute indices, multiply, accumulate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_q <= row_ext;
      col_q <= col_ext;
      err_q <= !in_range;
    end
    prod_q <= $signed(a_rdata) * $signed(b_rdata);
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // Alpha times the dot product, one slice per step from the top down.
  assign dot_pad  = PAD_W'(acc_q);
  assign chunk    = dot_pad[chunk_q*CW +: CW];
  assign chunk_op = {(chunk_q == TOP_CHUNK) ? chunk[CW-1] : 1'b0, chunk};
  assign part     = $signed(cfg_i.alpha) * chunk_op;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_step) begin
      if (chunk_q == TOP_CHUNK) begin
        r_q <= R_W'(part);
      end else begin
        r_q <= (r_q <<< CW) + R_W'(part);
      end
      bc_q <= $signed(cfg_i.beta) * $signed(c_rdata);
    end
  end

  // Floor the Q24.24 term to Q16.16, add beta*C, saturate.
  assign scaled = $signed(r_q[R_W-1:8]);
  assign sum    = S_W'(scaled) + S_W'(bc_q);

  always_comb begin
    if (sum > SAT_HI) begin
      sat = RW_OUT'(SAT_HI);
    end else if (sum < SAT_LO) begin
      sat = RW_OUT'(SAT_LO);
    end else begin
      sat = sum[RW_OUT-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      rsp_row_o    <= row_q[smma_pkg::IDX_W-1:0];
      rsp_col_o    <= col_q[smma_pkg::IDX_W-1:0];
      rsp_result_o <= err_q ? '0 : sat;
      rsp_error_o  <= err_q;
    end
  end

endmodule

### rtl/scaled_matrix_multiply_accumulate_unit.sv
// Top level of the scaled matrix multiply-accumulate unit, C = alpha*A*B + beta*C.
// Usage:
//   req_i carries requests: kind selects load A, load B, load C or compute;
//   row/col index the element; value is a signed Q8.8 element for loads.
//   rsp_o returns one result per compute request: the echoed row and column,
//   the Q16.16 saturated element and range_error. Loads return nothing.
//   The APB port holds the sizes and the Q8.8 gains; write it with no request in flight.
// Timing:
//   Loads stream at one per cycle while idle; a compute in progress holds
//   them off. An in-range compute walks the inner size K, drains the read
//   and product stages, scales the dot product in NCH 16-bit slices (3 at
//   the default sizes), then loads the result. The walk over K is one
//   multiply-accumulate per cycle through the A and B store read ports; the
//   alpha scaling takes one slice per cycle on a 16x17 multiplier. An
//   out-of-range compute skips to the final step and returns a zero result.
// Reset and stall:
//   Reset returns the registers to their defaults and empties the sequencer;
//   store contents stay undefined until loaded. A result waits in the output
//   register while rsp_o.ready is low; the next request is still accepted and
//   a following compute holds in its final step until the register frees.
module scaled_matrix_multiply_accumulate_unit #(
  parameter int MAX_DIM   = smma_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = smma_pkg::ELEM_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  smma_req_if.sink                     req_i,
  smma_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smma_pkg::PADDR_W-1:0] paddr,
  input  logic [smma_pkg::PDATA_W-1:0] pwdata,
  output logic [smma_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  smma_pkg::cfg_t       cfg;
  smma_pkg::ctrl_cmd_t  cmd;
  smma_pkg::dp_status_t stat;

  // Register file: raw values for readback, clamped sizes toward the core.
  smma_regs #(.MAX_DIM(MAX_DIM)) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer owns the handshakes; the datapath only follows commands.
  smma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .stat_i      (stat),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  smma_dp #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_kind_i   (req_i.kind),
    .req_row_i    (req_i.row),
    .req_col_i    (req_i.col),
    .req_value_i  (req_i.value),
    .rsp_row_o    (rsp_o.out_row),
    .rsp_col_o    (rsp_o.out_col),
    .rsp_result_o (rsp_o.result),
    .rsp_error_o  (rsp_o.range_error)
  );

endmodule
